FILE: rtl/bmhpq_pkg.sv
package bmhpq_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;
  localparam int DATA_W         = 32;
  localparam int STATUS_W       = 2;
  localparam int COUNT_OUT_W    = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_INS_START,
    DP_RD_PARENT,
    DP_INS_STEP,
    DP_REM_START,
    DP_RD_LAST,
    DP_LOAD_LAST,
    DP_RD_KIDS,
    DP_DN_STEP,
    DP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t st;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last_one;
    logic ins_stop;
    logic dn_stop;
  } dp_stat_t;

endpackage

FILE: rtl/bmhpq_ctrl.sv
module bmhpq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_opcode,
  input  bmhpq_pkg::dp_stat_t stat,
  output bmhpq_pkg::dp_cmd_t  cmd,
  output logic                busy
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_INS_RD   = 8'b0000_0010,
    S_INS_CMP  = 8'b0000_0100,
    S_REM_RD   = 8'b0000_1000,
    S_REM_LOAD = 8'b0001_0000,
    S_DN_RD    = 8'b0010_0000,
    S_DN_CMP   = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = bmhpq_pkg::DP_NOP;
    cmd.st    = bmhpq_pkg::ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_opcode == bmhpq_pkg::OP_INSERT) begin
            if (stat.full) begin
              cmd.op = bmhpq_pkg::DP_FINISH;
              cmd.st = bmhpq_pkg::ST_FULL;
            end else begin
              cmd.op    = bmhpq_pkg::DP_INS_START;
              state_nxt = S_INS_RD;
            end
          end else begin
            if (stat.empty) begin
              cmd.op = bmhpq_pkg::DP_FINISH;
              cmd.st = bmhpq_pkg::ST_EMPTY;
            end else begin
              cmd.op    = bmhpq_pkg::DP_REM_START;
              state_nxt = stat.last_one ? S_DONE : S_REM_RD;
            end
          end
        end
      end
      S_INS_RD: begin
        cmd.op    = bmhpq_pkg::DP_RD_PARENT;
        state_nxt = S_INS_CMP;
      end
      S_INS_CMP: begin
        cmd.op    = bmhpq_pkg::DP_INS_STEP;
        state_nxt = stat.ins_stop ? S_DONE : S_INS_RD;
      end
      S_REM_RD: begin
        cmd.op    = bmhpq_pkg::DP_RD_LAST;
        state_nxt = S_REM_LOAD;
      end
      S_REM_LOAD: begin
        cmd.op    = bmhpq_pkg::DP_LOAD_LAST;
        state_nxt = S_DN_RD;
      end
      S_DN_RD: begin
        cmd.op    = bmhpq_pkg::DP_RD_KIDS;
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.op    = bmhpq_pkg::DP_DN_STEP;
        state_nxt = stat.dn_stop ? S_DONE : S_DN_RD;
      end
      S_DONE: begin
        cmd.op    = bmhpq_pkg::DP_FINISH;
        cmd.st    = bmhpq_pkg::ST_OK;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/bmhpq_dp.sv
module bmhpq_dp #(
  parameter int CAPACITY   = bmhpq_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = bmhpq_pkg::VALUE_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  bmhpq_pkg::dp_cmd_t                       cmd,
  input  logic signed [bmhpq_pkg::DATA_W-1:0]      in_value,
  output bmhpq_pkg::dp_stat_t                      stat,
  output logic                                     out_valid,
  output logic        [bmhpq_pkg::STATUS_W-1:0]    out_status,
  output logic signed [bmhpq_pkg::DATA_W-1:0]      out_removed_value,
  output logic signed [bmhpq_pkg::DATA_W-1:0]      out_top_value,
  output logic        [bmhpq_pkg::COUNT_OUT_W-1:0] out_entry_count,
  output logic                                     out_is_empty
);

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = PW + 2;

  logic signed [VALUE_BITS-1:0] mem [CAPACITY];

  logic        [CW-1:0]         cnt_r;
  logic        [PW-1:0]         pos_r;
  logic signed [VALUE_BITS-1:0] val_r;
  logic signed [VALUE_BITS-1:0] top_r;
  logic signed [VALUE_BITS-1:0] removed_r;
  logic signed [VALUE_BITS-1:0] rd_a_r;
  logic signed [VALUE_BITS-1:0] rd_b_r;
  logic                         valid_r;

  logic                         we;
  logic        [PW-1:0]         waddr;
  logic signed [VALUE_BITS-1:0] wdata;
  logic        [PW-1:0]         raddr_a;
  logic        [PW-1:0]         raddr_b;

  logic        [PW-1:0]         pos_m1;
  logic        [PW-1:0]         parent;
  logic        [IW-1:0]         lchild;
  logic        [IW-1:0]         rchild;
  logic        [IW-1:0]         cnt_ext;
  logic                         l_ok;
  logic                         r_ok;
  logic                         lgt;
  logic                         rgt;
  logic                         ins_gt;

  assign pos_m1  = pos_r - PW'(1);
  assign parent  = (pos_r == '0) ? '0 : (pos_m1 >> 1);
  assign lchild  = {1'b0, pos_r, 1'b1};
  assign rchild  = lchild + IW'(1);
  assign cnt_ext = IW'(cnt_r);
  assign l_ok    = (lchild < cnt_ext);
  assign r_ok    = (rchild < cnt_ext);
  assign lgt     = l_ok && (rd_a_r > val_r);
  assign rgt     = r_ok && (lgt ? (rd_b_r > rd_a_r) : (rd_b_r > val_r));
  assign ins_gt  = (val_r > rd_a_r);

  assign stat.full     = (cnt_r == CW'(CAPACITY));
  assign stat.empty    = (cnt_r == '0);
  assign stat.last_one = (cnt_r == CW'(1));
  assign stat.ins_stop = (pos_r == '0) || !ins_gt;
  assign stat.dn_stop  = !lgt && !rgt;

  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    we      = 1'b0;
    waddr   = pos_r;
    wdata   = val_r;
    case (cmd.op)
      bmhpq_pkg::DP_RD_PARENT: begin
        raddr_a = parent;
      end
      bmhpq_pkg::DP_RD_LAST: begin
        raddr_a = cnt_r[PW-1:0];
      end
      bmhpq_pkg::DP_RD_KIDS: begin
        raddr_a = l_ok ? lchild[PW-1:0] : '0;
        raddr_b = r_ok ? rchild[PW-1:0] : '0;
      end
      bmhpq_pkg::DP_INS_STEP: begin
        we    = 1'b1;
        wdata = stat.ins_stop ? val_r : rd_a_r;
      end
      bmhpq_pkg::DP_DN_STEP: begin
        we    = 1'b1;
        wdata = rgt ? rd_b_r : (lgt ? rd_a_r : val_r);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= (cmd.op == bmhpq_pkg::DP_FINISH);
      if (cmd.op == bmhpq_pkg::DP_INS_START) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.op == bmhpq_pkg::DP_REM_START) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      bmhpq_pkg::DP_INS_START: begin
        val_r     <= VALUE_BITS'(in_value);
        pos_r     <= cnt_r[PW-1:0];
        removed_r <= '0;
      end
      bmhpq_pkg::DP_REM_START: begin
        removed_r <= top_r;
        pos_r     <= '0;
      end
      bmhpq_pkg::DP_LOAD_LAST: begin
        val_r <= rd_a_r;
      end
      bmhpq_pkg::DP_INS_STEP: begin
        if (!stat.ins_stop) begin
          pos_r <= parent;
        end
      end
      bmhpq_pkg::DP_DN_STEP: begin
        if (rgt) begin
          pos_r <= rchild[PW-1:0];
        end else if (lgt) begin
          pos_r <= lchild[PW-1:0];
        end
      end
      default: begin
        pos_r <= pos_r;
      end
    endcase
    if (we && (waddr == '0)) begin
      top_r <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == bmhpq_pkg::DP_FINISH) begin
      out_status        <= cmd.st;
      out_removed_value <= (cmd.st == bmhpq_pkg::ST_OK) ?
                           bmhpq_pkg::DATA_W'(removed_r) : '0;
      out_top_value     <= (cnt_r == '0) ? '0 : bmhpq_pkg::DATA_W'(top_r);
      out_entry_count   <= bmhpq_pkg::COUNT_OUT_W'(cnt_r);
      out_is_empty      <= (cnt_r == '0);
    end
  end

  assign out_valid = valid_r;

endmodule

FILE: rtl/binary_max_heap_priority_queue.sv
// Channel  | Handshake          | Ports
// ---------+--------------------+----------------------------------------------
// request  | start & !busy      | in_opcode, in_value
// result   | out_valid (1 clk)  | out_status, out_removed_value, out_top_value,
//          |                    | out_entry_count, out_is_empty
//
// One request at a time; busy stays high until its result is registered.
// Insert climbs from the new slot toward the root. Remove loads the last entry at
// the root and sinks it; taking the only entry skips that. Refused requests return
// their result the next cycle. One write port and two registered read ports split
// each level climbed or descended into a read step and a compare step. Reset clears
// the count, the result strobe and the controller state only. Results cannot stall.
module binary_max_heap_priority_queue #(
  parameter int CAPACITY   = bmhpq_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = bmhpq_pkg::VALUE_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic                                     busy,
  input  logic                                     in_opcode,
  input  logic signed [bmhpq_pkg::DATA_W-1:0]      in_value,
  output logic                                     out_valid,
  output logic        [bmhpq_pkg::STATUS_W-1:0]    out_status,
  output logic signed [bmhpq_pkg::DATA_W-1:0]      out_removed_value,
  output logic signed [bmhpq_pkg::DATA_W-1:0]      out_top_value,
  output logic        [bmhpq_pkg::COUNT_OUT_W-1:0] out_entry_count,
  output logic                                     out_is_empty
);

  bmhpq_pkg::dp_cmd_t  cmd;
  bmhpq_pkg::dp_stat_t stat;
  logic                accept;

  assign accept = start && !busy;

  bmhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  bmhpq_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_value          (in_value),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_top_value     (out_top_value),
    .out_entry_count   (out_entry_count),
    .out_is_empty      (out_is_empty)
  );

`ifndef ASSERT_OFF
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("request accepted but neither busy nor result next cycle");

  a_refused_no_removed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != bmhpq_pkg::ST_OK)) |-> (out_removed_value == '0))
    else $error("refused request reports a removed value");

  a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> ((out_top_value == '0) && (out_entry_count == '0)))
    else $error("empty heap reports a top value or count");

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobe while request in progress");
`endif

endmodule
